@@ src/pbs_pkg.sv @@
package pbs_pkg;

  // Q16.16 limits and model constants
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic [31:0] PI_Q        = 32'd205887;
  localparam logic [31:0] TWO_PI_Q    = 32'd411775;
  localparam logic [31:0] HALF_PI_Q   = 32'd102944;
  localparam logic [31:0] K43_Q       = 32'd87381;
  localparam logic [31:0] LIM_POS_Q   = 32'd157286;
  localparam logic [31:0] FORCE_Q     = 32'd3276800;
  localparam logic [32:0] CORDIC_GAIN = 33'd652032874;

  localparam logic [5:0] RED_LAST = 6'd12;
  localparam logic [5:0] COR_LAST = 6'd27;
  localparam logic [5:0] DIV_LAST = 6'd47;

  localparam logic [1:0] ACT_LEFT  = 2'd0;
  localparam logic [1:0] ACT_RIGHT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_GRAVITY  = 3'd0;
  localparam logic [2:0] REG_MASS     = 3'd1;
  localparam logic [2:0] REG_LENGTH   = 3'd2;
  localparam logic [2:0] REG_INV_MASS = 3'd3;
  localparam logic [2:0] REG_TSTEP    = 3'd4;
  localparam logic [2:0] REG_SUBSTEPS = 3'd5;

  // datapath commands
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_ACCEPT   = 4'd1;
  localparam logic [3:0] OP_RESET_EP = 4'd2;
  localparam logic [3:0] OP_ENDED    = 4'd3;
  localparam logic [3:0] OP_LOAD_U   = 4'd4;
  localparam logic [3:0] OP_RED_INIT = 4'd5;
  localparam logic [3:0] OP_RED_STEP = 4'd6;
  localparam logic [3:0] OP_COR_INIT = 4'd7;
  localparam logic [3:0] OP_COR_STEP = 4'd8;
  localparam logic [3:0] OP_COR_FIN  = 4'd9;
  localparam logic [3:0] OP_MUL      = 4'd10;
  localparam logic [3:0] OP_WB       = 4'd11;
  localparam logic [3:0] OP_DIV_INIT = 4'd12;
  localparam logic [3:0] OP_DIV_STEP = 4'd13;
  localparam logic [3:0] OP_DIV_FIN  = 4'd14;
  localparam logic [3:0] OP_CHECK    = 4'd15;

  // operand and destination selects
  localparam logic [4:0] R_ZERO = 5'd0;
  localparam logic [4:0] R_ANG  = 5'd1;
  localparam logic [4:0] R_RATE = 5'd2;
  localparam logic [4:0] R_POS  = 5'd3;
  localparam logic [4:0] R_VEL  = 5'd4;
  localparam logic [4:0] R_U    = 5'd5;
  localparam logic [4:0] R_SX   = 5'd6;
  localparam logic [4:0] R_CX   = 5'd7;
  localparam logic [4:0] R_D2   = 5'd8;
  localparam logic [4:0] R_CML  = 5'd9;
  localparam logic [4:0] R_T0   = 5'd10;
  localparam logic [4:0] R_T1   = 5'd11;
  localparam logic [4:0] R_T2   = 5'd12;
  localparam logic [4:0] R_NUM  = 5'd13;
  localparam logic [4:0] R_DEN  = 5'd14;
  localparam logic [4:0] R_ACC  = 5'd15;
  localparam logic [4:0] R_G    = 5'd16;
  localparam logic [4:0] R_M    = 5'd17;
  localparam logic [4:0] R_L    = 5'd18;
  localparam logic [4:0] R_CM   = 5'd19;
  localparam logic [4:0] R_DT   = 5'd20;
  localparam logic [4:0] R_K43  = 5'd21;

  // micro-op modes
  localparam logic [1:0] M_MUL  = 2'd0;
  localparam logic [1:0] M_MADD = 2'd1;
  localparam logic [1:0] M_MSUB = 2'd2;
  localparam logic [1:0] M_ADD  = 2'd3;

  localparam logic [4:0] UOP_DEN  = 5'd11;
  localparam logic [4:0] UOP_LAST = 5'd16;

  typedef struct packed {
    logic [20:0] gravity;
    logic [18:0] pend_mass;
    logic [17:0] pend_length;
    logic [16:0] inv_total_mass;
    logic [12:0] time_step;
    logic [5:0]  substeps;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [5:0] idx;
    logic [4:0] uop;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic over;
  } stat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] c;
    logic [4:0] dst;
  } uop_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd843314856;
      5'd1: v = 30'd497837829;
      5'd2: v = 30'd263043836;
      5'd3: v = 30'd133525158;
      5'd4: v = 30'd67021686;
      5'd5: v = 30'd33543515;
      5'd6: v = 30'd16775850;
      5'd7: v = 30'd8388437;
      5'd8: v = 30'd4194282;
      5'd9: v = 30'd2097149;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  // one Euler substep after sine/cosine; the divide runs after UOP_DEN
  function automatic uop_t uop_rom(input logic [4:0] k);
    uop_t u;
    case (k)
      5'd0:  u = '{M_MUL,  R_RATE, R_RATE, R_ZERO, R_D2};
      5'd1:  u = '{M_MUL,  R_CM,   R_M,    R_ZERO, R_T0};
      5'd2:  u = '{M_MUL,  R_T0,   R_L,    R_ZERO, R_CML};
      5'd3:  u = '{M_MUL,  R_G,    R_SX,   R_ZERO, R_T0};
      5'd4:  u = '{M_MUL,  R_CML,  R_D2,   R_ZERO, R_T1};
      5'd5:  u = '{M_MUL,  R_SX,   R_CX,   R_ZERO, R_T2};
      5'd6:  u = '{M_MSUB, R_T1,   R_T2,   R_T0,   R_NUM};
      5'd7:  u = '{M_MUL,  R_CM,   R_CX,   R_ZERO, R_T0};
      5'd8:  u = '{M_MSUB, R_T0,   R_U,    R_NUM,  R_NUM};
      5'd9:  u = '{M_MUL,  R_CX,   R_CX,   R_ZERO, R_T0};
      5'd10: u = '{M_MUL,  R_K43,  R_L,    R_ZERO, R_T1};
      5'd11: u = '{M_MSUB, R_CML,  R_T0,   R_T1,   R_DEN};
      5'd12: u = '{M_MADD, R_RATE, R_DT,   R_ANG,  R_ANG};
      5'd13: u = '{M_MADD, R_ACC,  R_DT,   R_RATE, R_RATE};
      5'd14: u = '{M_MADD, R_VEL,  R_DT,   R_POS,  R_POS};
      5'd15: u = '{M_ADD,  R_U,    R_SX,   R_ZERO, R_T0};
      5'd16: u = '{M_MADD, R_T0,   R_DT,   R_VEL,  R_VEL};
      default: u = '{M_MUL, R_ZERO, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(VMAX)) begin
      r = VMAX;
    end else if (v < 34'(VMIN)) begin
      r = VMIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/pbs_cfg.sv @@
module pbs_cfg import pbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity        <= 21'd642253;
      cfg_r.pend_mass      <= 19'd131072;
      cfg_r.pend_length    <= 18'd32768;
      cfg_r.inv_total_mass <= 17'd6554;
      cfg_r.time_step      <= 13'd655;
      cfg_r.substeps       <= 6'd11;
    end else if (wr_en) begin
      case (idx)
        REG_GRAVITY:  cfg_r.gravity        <= cfg_pwdata[20:0];
        REG_MASS:     cfg_r.pend_mass      <= cfg_pwdata[18:0];
        REG_LENGTH:   cfg_r.pend_length    <= cfg_pwdata[17:0];
        REG_INV_MASS: cfg_r.inv_total_mass <= cfg_pwdata[16:0];
        REG_TSTEP:    cfg_r.time_step      <= cfg_pwdata[12:0];
        REG_SUBSTEPS: cfg_r.substeps       <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRAVITY:  cfg_prdata = {11'd0, cfg_r.gravity};
      REG_MASS:     cfg_prdata = {13'd0, cfg_r.pend_mass};
      REG_LENGTH:   cfg_prdata = {14'd0, cfg_r.pend_length};
      REG_INV_MASS: cfg_prdata = {15'd0, cfg_r.inv_total_mass};
      REG_TSTEP:    cfg_prdata = {19'd0, cfg_r.time_step};
      REG_SUBSTEPS: cfg_prdata = {26'd0, cfg_r.substeps};
      default:      cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ src/pbs_dp.sv @@
module pbs_dp import pbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  output stat_t              stat,
  input  logic [1:0]         in_action,
  input  logic signed [17:0] in_noise,
  input  logic signed [17:0] in_start_angle,
  input  logic signed [17:0] in_start_rate,
  output logic signed [31:0] out_angle,
  output logic signed [31:0] out_angle_rate,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity,
  output logic               out_reward,
  output logic               out_running
);

  localparam logic signed [21:0] PI22      = 22'sd205887;
  localparam logic signed [21:0] TWO_PI22  = 22'sd411775;
  localparam logic signed [21:0] HALF_PI22 = 22'sd102944;

  logic [1:0]         action_r;
  logic signed [17:0] noise_r, sa_r, sr_r;

  logic signed [31:0] ang_r, rate_r, pos_r, vel_r, u_r, sx_r, cx_r, d2_r, cml_r;
  logic signed [31:0] t0_r, t1_r, t2_r, num_r, den_r, acc_r;
  logic               over_r, reward_r, running_r;

  logic [63:0]        prod_r;
  logic               pneg_r;

  logic [31:0]        red_m_r;
  logic               red_neg_r;

  logic signed [32:0] cx33_r, cy33_r, cz33_r;
  logic               flip_r;

  logic [47:0]        div_rq_r;
  logic [31:0]        div_rem_r, div_d_r;
  logic               div_neg_r, div_dz_r, div_nz_r, div_npos_r;

  uop_t               u;
  logic signed [31:0] src [32];
  logic signed [31:0] opa, opb, opc;
  logic [31:0]        ma, mb;

  logic [47:0]        pr;
  logic [31:0]        cap, pm;
  logic signed [33:0] pval, wsum;
  logic signed [31:0] wval;

  logic [31:0]        red_sub;
  logic signed [21:0] rr, r1, r2;
  logic               flip;
  logic signed [32:0] z0;

  logic [4:0]         ci;
  logic signed [32:0] dx, dy, at, ys, xs;

  logic [31:0]        un, ud;
  logic [32:0]        rem2, rdiff;
  logic               ge;
  logic signed [31:0] q_val;

  logic [31:0]        am, pmag;
  logic               over_now;
  logic signed [31:0] force_q;

  assign u = uop_rom(cmd.uop);

  always_comb begin
    src = '{default: '0};
    src[R_ANG]  = ang_r;
    src[R_RATE] = rate_r;
    src[R_POS]  = pos_r;
    src[R_VEL]  = vel_r;
    src[R_U]    = u_r;
    src[R_SX]   = sx_r;
    src[R_CX]   = cx_r;
    src[R_D2]   = d2_r;
    src[R_CML]  = cml_r;
    src[R_T0]   = t0_r;
    src[R_T1]   = t1_r;
    src[R_T2]   = t2_r;
    src[R_NUM]  = num_r;
    src[R_DEN]  = den_r;
    src[R_ACC]  = acc_r;
    src[R_G]    = $signed({11'd0, cfg.gravity});
    src[R_M]    = $signed({13'd0, cfg.pend_mass});
    src[R_L]    = $signed({14'd0, cfg.pend_length});
    src[R_CM]   = $signed({15'd0, cfg.inv_total_mass});
    src[R_DT]   = $signed({19'd0, cfg.time_step});
    src[R_K43]  = $signed(K43_Q);
  end

  assign opa = src[u.a];
  assign opb = src[u.b];
  assign opc = src[u.c];
  assign ma  = opa[31] ? (~opa + 32'd1) : opa;
  assign mb  = opb[31] ? (~opb + 32'd1) : opb;

  // product magnitude, shifted and capped, then combined
  always_comb begin
    pr   = prod_r[63:16];
    cap  = pneg_r ? 32'h8000_0000 : 32'h7fff_ffff;
    pm   = (pr > {16'd0, cap}) ? cap : pr[31:0];
    pval = pneg_r ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
    case (u.mode)
      M_MUL:   wsum = pval;
      M_MADD:  wsum = 34'(opc) + pval;
      M_MSUB:  wsum = 34'(opc) - pval;
      M_ADD:   wsum = 34'(opa) + 34'(opb);
      default: wsum = pval;
    endcase
    wval = sat34(wsum);
  end

  // angle reduction into [-pi/2, pi/2]
  always_comb begin
    red_sub = TWO_PI_Q << cmd.idx[3:0];
    rr = red_neg_r ? -$signed({3'b000, red_m_r[18:0]}) : $signed({3'b000, red_m_r[18:0]});
    if (rr > PI22) begin
      r1 = rr - TWO_PI22;
    end else if (rr < -PI22) begin
      r1 = rr + TWO_PI22;
    end else begin
      r1 = rr;
    end
    flip = 1'b0;
    r2   = r1;
    if (r1 > HALF_PI22) begin
      r2   = PI22 - r1;
      flip = 1'b1;
    end else if (r1 < -HALF_PI22) begin
      r2   = -PI22 - r1;
      flip = 1'b1;
    end
    z0 = 33'(r2) <<< 14;
  end

  always_comb begin
    ci = cmd.idx[4:0];
    dx = cy33_r >>> ci;
    dy = cx33_r >>> ci;
    at = $signed({3'b000, atan_q30(ci)});
    ys = (cy33_r + 33'sd8192) >>> 14;
    xs = (cx33_r + 33'sd8192) >>> 14;
  end

  always_comb begin
    un    = num_r[31] ? (~num_r + 32'd1) : num_r;
    ud    = den_r[31] ? (~den_r + 32'd1) : den_r;
    rem2  = {div_rem_r, div_rq_r[47]};
    rdiff = rem2 - {1'b0, div_d_r};
    ge    = rem2 >= {1'b0, div_d_r};
    if (div_dz_r) begin
      q_val = div_nz_r ? 32'sd0 : (div_npos_r ? VMAX : VMIN);
    end else if (|div_rq_r[47:31]) begin
      q_val = div_neg_r ? VMIN : VMAX;
    end else begin
      q_val = div_neg_r ? -$signed({1'b0, div_rq_r[30:0]}) : $signed({1'b0, div_rq_r[30:0]});
    end
  end

  always_comb begin
    am       = ang_r[31] ? (~ang_r + 32'd1) : ang_r;
    pmag     = pos_r[31] ? (~pos_r + 32'd1) : pos_r;
    over_now = (am > HALF_PI_Q) || (pmag > LIM_POS_Q);
    case (action_r)
      ACT_LEFT:  force_q = -$signed(FORCE_Q);
      ACT_RIGHT: force_q = $signed(FORCE_Q);
      default:   force_q = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r     <= '0;
      rate_r    <= '0;
      pos_r     <= '0;
      vel_r     <= '0;
      over_r    <= 1'b0;
      reward_r  <= 1'b0;
      running_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          action_r <= in_action;
          noise_r  <= in_noise;
          sa_r     <= in_start_angle;
          sr_r     <= in_start_rate;
        end
        OP_RESET_EP: begin
          ang_r     <= 32'(sa_r);
          rate_r    <= 32'(sr_r);
          pos_r     <= '0;
          vel_r     <= '0;
          over_r    <= 1'b0;
          reward_r  <= 1'b1;
          running_r <= 1'b1;
        end
        OP_ENDED: begin
          reward_r  <= 1'b0;
          running_r <= 1'b0;
        end
        OP_LOAD_U: u_r <= force_q + 32'(noise_r);
        OP_RED_INIT: begin
          red_m_r   <= am;
          red_neg_r <= ang_r[31];
        end
        OP_RED_STEP: begin
          if (red_m_r >= red_sub) begin
            red_m_r <= red_m_r - red_sub;
          end
        end
        OP_COR_INIT: begin
          cx33_r <= $signed(CORDIC_GAIN);
          cy33_r <= '0;
          cz33_r <= z0;
          flip_r <= flip;
        end
        OP_COR_STEP: begin
          if (!cz33_r[32]) begin
            cx33_r <= cx33_r - dx;
            cy33_r <= cy33_r + dy;
            cz33_r <= cz33_r - at;
          end else begin
            cx33_r <= cx33_r + dx;
            cy33_r <= cy33_r - dy;
            cz33_r <= cz33_r + at;
          end
        end
        OP_COR_FIN: begin
          sx_r <= 32'(ys);
          cx_r <= flip_r ? -32'(xs) : 32'(xs);
        end
        OP_MUL: begin
          prod_r <= ma * mb;
          pneg_r <= opa[31] ^ opb[31];
        end
        OP_WB: begin
          case (u.dst)
            R_ANG:  ang_r  <= wval;
            R_RATE: rate_r <= wval;
            R_POS:  pos_r  <= wval;
            R_VEL:  vel_r  <= wval;
            R_D2:   d2_r   <= wval;
            R_CML:  cml_r  <= wval;
            R_T0:   t0_r   <= wval;
            R_T1:   t1_r   <= wval;
            R_T2:   t2_r   <= wval;
            R_NUM:  num_r  <= wval;
            R_DEN:  den_r  <= wval;
            default: ;
          endcase
        end
        OP_DIV_INIT: begin
          div_rq_r   <= {un, 16'd0};
          div_rem_r  <= '0;
          div_d_r    <= ud;
          div_neg_r  <= num_r[31] ^ den_r[31];
          div_dz_r   <= (den_r == 32'sd0);
          div_nz_r   <= (num_r == 32'sd0);
          div_npos_r <= !num_r[31];
        end
        OP_DIV_STEP: begin
          div_rem_r <= ge ? rdiff[31:0] : rem2[31:0];
          div_rq_r  <= {div_rq_r[46:0], ge};
        end
        OP_DIV_FIN: acc_r <= q_val;
        OP_CHECK: begin
          over_r    <= over_now;
          reward_r  <= !over_now;
          running_r <= !over_now;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_angle      <= ang_r;
      out_angle_rate <= rate_r;
      out_position   <= pos_r;
      out_velocity   <= vel_r;
      out_reward     <= reward_r;
      out_running    <= running_r;
    end
  end

  assign stat.over = over_r;

endmodule

@@ src/pbs_ctrl.sv @@
module pbs_ctrl import pbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic [5:0] substeps,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RST_EP   = 4'd1;
  localparam logic [3:0] S_ENDED    = 4'd2;
  localparam logic [3:0] S_LOAD_U   = 4'd3;
  localparam logic [3:0] S_RED_INIT = 4'd4;
  localparam logic [3:0] S_RED      = 4'd5;
  localparam logic [3:0] S_COR_INIT = 4'd6;
  localparam logic [3:0] S_COR      = 4'd7;
  localparam logic [3:0] S_COR_FIN  = 4'd8;
  localparam logic [3:0] S_MUL      = 4'd9;
  localparam logic [3:0] S_WB       = 4'd10;
  localparam logic [3:0] S_DIV_INIT = 4'd11;
  localparam logic [3:0] S_DIV      = 4'd12;
  localparam logic [3:0] S_DIV_FIN  = 4'd13;
  localparam logic [3:0] S_CHECK    = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] sub_r, sub_nxt;
  logic [4:0] uop_r, uop_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    sub_nxt      = sub_r;
    uop_nxt      = uop_r;
    cmd          = '0;
    cmd.idx      = cnt_r;
    cmd.uop      = uop_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_kind) begin
            state_nxt = S_RST_EP;
          end else if (stat.over) begin
            state_nxt = S_ENDED;
          end else begin
            state_nxt = S_LOAD_U;
          end
        end
      end
      S_RST_EP: begin
        cmd.op    = OP_RESET_EP;
        state_nxt = S_DONE;
      end
      S_ENDED: begin
        cmd.op    = OP_ENDED;
        state_nxt = S_DONE;
      end
      S_LOAD_U: begin
        cmd.op    = OP_LOAD_U;
        sub_nxt   = '0;
        state_nxt = (substeps == 6'd0) ? S_CHECK : S_RED_INIT;
      end
      S_RED_INIT: begin
        cmd.op    = OP_RED_INIT;
        cnt_nxt   = RED_LAST;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.op = OP_RED_STEP;
        if (cnt_r == 6'd0) begin
          state_nxt = S_COR_INIT;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_COR_INIT: begin
        cmd.op    = OP_COR_INIT;
        cnt_nxt   = '0;
        state_nxt = S_COR;
      end
      S_COR: begin
        cmd.op = OP_COR_STEP;
        if (cnt_r == COR_LAST) begin
          state_nxt = S_COR_FIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_COR_FIN: begin
        cmd.op    = OP_COR_FIN;
        uop_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.op = OP_WB;
        if (uop_r == UOP_DEN) begin
          state_nxt = S_DIV_INIT;
        end else if (uop_r == UOP_LAST) begin
          sub_nxt   = sub_r + 6'd1;
          state_nxt = (sub_nxt == substeps) ? S_CHECK : S_RED_INIT;
        end else begin
          uop_nxt   = uop_r + 5'd1;
          state_nxt = S_MUL;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = DIV_LAST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == 6'd0) begin
          state_nxt = S_DIV_FIN;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_DIV_FIN: begin
        cmd.op    = OP_DIV_FIN;
        uop_nxt   = UOP_DEN + 5'd1;
        state_nxt = S_MUL;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sub_r       <= '0;
      uop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sub_r       <= sub_nxt;
      uop_r       <= uop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not return to idle with a valid result");

  a_cor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COR) |-> (cnt_r <= COR_LAST))
    else $error("rotation index out of range");

  a_uop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_WB) |-> (uop_r <= UOP_LAST))
    else $error("micro-op index out of range");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_INIT) |-> ($past(state_r) == S_WB && $past(uop_r) == UOP_DEN))
    else $error("divide started before the denominator was written");
`endif

endmodule

@@ src/pole_balance_sim_step_unit.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in_      | in_valid / in_stall  | kind, action, noise, start_angle, start_rate
// out_     | out_valid / out_stall| angle, angle_rate, position, velocity, reward, running
// cfg_     | APB write/read       | gravity .. substeps at byte address 4*i
//
// Reset and ended-episode requests go straight to the result; an act request runs substeps
// Euler substeps (eleven by default). Each substep is an angle reduction by 2*pi shifted
// from 12 down to 0, 28 CORDIC rotations, 17 passes through the shared multiplier and a
// bit-serial divide. One request is in work at a time; a finished result waits
// in the output register so the next request is taken while out_stall is high.
// rst_n is synchronous; it clears the control and the pole and cart state.
module pole_balance_sim_step_unit import pbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [1:0]         in_action,
  input  logic signed [17:0] in_noise,
  input  logic signed [17:0] in_start_angle,
  input  logic signed [17:0] in_start_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_angle,
  output logic signed [31:0] out_angle_rate,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity,
  output logic               out_reward,
  output logic               out_running,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  pbs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .substeps  (cfg.substeps),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .stat           (stat),
    .in_action      (in_action),
    .in_noise       (in_noise),
    .in_start_angle (in_start_angle),
    .in_start_rate  (in_start_rate),
    .out_angle      (out_angle),
    .out_angle_rate (out_angle_rate),
    .out_position   (out_position),
    .out_velocity   (out_velocity),
    .out_reward     (out_reward),
    .out_running    (out_running)
  );

endmodule

@@ bench/pole_balance_sim_step_checker.sv @@
module pole_balance_sim_step_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [1:0]         in_action,
  input  logic signed [17:0] in_noise,
  input  logic signed [17:0] in_start_angle,
  input  logic signed [17:0] in_start_rate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_angle,
  input  logic signed [31:0] out_angle_rate,
  input  logic signed [31:0] out_position,
  input  logic signed [31:0] out_velocity,
  input  logic               out_reward,
  input  logic               out_running,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 mismatches,
  output int                 awaited,
  output int                 states_seen,
  output int                 episodes_ended
);
  import pbs_pkg::*;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] angle_rate;
    logic [31:0] position;
    logic [31:0] velocity;
    logic        reward;
    logic        running;
  } pole_state_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  pole_state_t awaited_states[$];

  longint g_reg, m_reg, l_reg, cm_reg, dt_reg, nsub_reg;
  longint theta, omega, xpos, xvel;
  bit     ended, rewarded;

  longint arctan_q30[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};

  function automatic longint clamp_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint cap_signed(logic [63:0] m, bit neg);
    logic [63:0] lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] r;
    p = 128'(magnitude(a)) * 128'(magnitude(b));
    r = p >> 16;
    if (r[127:64] != 0) r = {64'd0, {64{1'b1}}};
    return cap_signed(r[63:0], (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint n, longint d);
    logic [63:0] un, ud, q;
    bit neg;
    un = magnitude(n);
    ud = magnitude(d);
    neg = (n < 0) != (d < 0);
    if (ud == 0) begin
      if (n == 0) return 0;
      return n > 0 ? QMAX : QMIN;
    end
    q = un / ud;
    if (q >= 64'd32768) return cap_signed({64{1'b1}}, neg);
    q = (un << 16) / ud;
    return cap_signed(q, neg);
  endfunction

  function automatic longint round_q32(longint c);
    return (c + 32768) >>> 16;
  endfunction

  function automatic void cordic_sin_cos(longint a, output longint s, output longint c);
    longint pi_q, two_pi_q, half_pi_q, r, x, y, z, dx, dy, step;
    bit flip;
    pi_q = round_q32(64'd13493037705);
    two_pi_q = round_q32(64'd26986075409);
    half_pi_q = round_q32(64'd6746518852);
    r = a % two_pi_q;
    flip = 0;
    x = 652032874;
    y = 0;
    if (r > pi_q) r -= two_pi_q;
    else if (r < -pi_q) r += two_pi_q;
    if (r > half_pi_q) begin
      r = pi_q - r;
      flip = 1;
    end else if (r < -half_pi_q) begin
      r = -pi_q - r;
      flip = 1;
    end
    z = r * 16384;
    for (int i = 0; i < 28; i++) begin
      step = (i < 10) ? arctan_q30[i] : (64'sd1 <<< (30 - i));
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= step;
      end else begin
        x += dx; y -= dy; z += step;
      end
    end
    s = (y + 8192) >>> 14;
    c = (x + 8192) >>> 14;
    if (flip) c = -c;
  endfunction

  function automatic void euler_substep(longint u);
    longint k43, sx, cx, d2, cml, num, den, acc, a0, w0, v0;
    k43 = ((64'sd4 <<< 16) + 1) / 3;
    a0 = theta;
    w0 = omega;
    v0 = xvel;
    cordic_sin_cos(a0, sx, cx);
    d2 = q_mul(w0, w0);
    cml = q_mul(q_mul(cm_reg, m_reg), l_reg);
    num = clamp_q(q_mul(g_reg, sx) - q_mul(q_mul(cml, d2), q_mul(sx, cx)));
    num = clamp_q(num - q_mul(q_mul(cm_reg, cx), u));
    den = clamp_q(q_mul(k43, l_reg) - q_mul(cml, q_mul(cx, cx)));
    acc = q_div(num, den);
    theta = clamp_q(a0 + q_mul(w0, dt_reg));
    omega = clamp_q(w0 + q_mul(acc, dt_reg));
    xpos = clamp_q(xpos + q_mul(v0, dt_reg));
    xvel = clamp_q(v0 + q_mul(clamp_q(u + sx), dt_reg));
  endfunction

  function automatic pole_state_t advance_pole(logic kind, logic [1:0] act,
                                               logic signed [17:0] noise,
                                               logic signed [17:0] sa,
                                               logic signed [17:0] sr);
    pole_state_t res;
    longint u;
    bit live;
    if (kind) begin
      theta = sa;
      omega = sr;
      xpos = 0;
      xvel = 0;
      rewarded = 1;
      ended = 0;
      live = 1;
    end else if (ended) begin
      rewarded = 0;
      live = 0;
    end else begin
      u = 0;
      if (act == ACT_LEFT) u = -(64'sd50 <<< 16);
      else if (act == ACT_RIGHT) u = 64'sd50 <<< 16;
      u = clamp_q(u + longint'(noise));
      for (longint k = 0; k < nsub_reg; k++) euler_substep(u);
      if (magnitude(theta) > 64'(round_q32(64'd6746518852)) ||
          magnitude(xpos) > 64'((64'sd12 <<< 16) / 5)) begin
        rewarded = 0;
        ended = 1;
        episodes_ended++;
      end else begin
        rewarded = 1;
        ended = 0;
      end
      live = !ended;
    end
    res.angle = theta[31:0];
    res.angle_rate = omega[31:0];
    res.position = xpos[31:0];
    res.velocity = xvel[31:0];
    res.reward = rewarded;
    res.running = live;
    return res;
  endfunction

  assign awaited = awaited_states.size();

  always @(posedge clk) begin
    pole_state_t want, got;
    if (!rst_n) begin
      g_reg = 642253; m_reg = 131072; l_reg = 32768;
      cm_reg = 6554; dt_reg = 655; nsub_reg = 11;
      theta = 0; omega = 0; xpos = 0; xvel = 0;
      ended = 0; rewarded = 0;
      awaited_states.delete();
      mismatches <= 0;
      states_seen <= 0;
      episodes_ended = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (3'(cfg_paddr >> 2))
          REG_GRAVITY:  g_reg = cfg_pwdata[20:0];
          REG_MASS:     m_reg = cfg_pwdata[18:0];
          REG_LENGTH:   l_reg = cfg_pwdata[17:0];
          REG_INV_MASS: cm_reg = cfg_pwdata[16:0];
          REG_TSTEP:    dt_reg = cfg_pwdata[12:0];
          REG_SUBSTEPS: nsub_reg = cfg_pwdata[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited_states.push_back(advance_pole(in_kind, in_action, in_noise,
                                              in_start_angle, in_start_rate));
      if (out_valid && !out_stall) begin
        got = '{out_angle, out_angle_rate, out_position, out_velocity,
                out_reward, out_running};
        states_seen <= states_seen + 1;
        if (awaited_states.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_states.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected ang=%0d rate=%0d pos=%0d vel=%0d rew=%0b run=%0b",
                     $time, $signed(want.angle), $signed(want.angle_rate),
                     $signed(want.position), $signed(want.velocity), want.reward,
                     want.running);
            $display("%0t:          actual   ang=%0d rate=%0d pos=%0d vel=%0d rew=%0b run=%0b",
                     $time, $signed(got.angle), $signed(got.angle_rate),
                     $signed(got.position), $signed(got.velocity), got.reward,
                     got.running);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/pole_balance_sim_step_unit_tb.sv @@
module pole_balance_sim_step_unit_tb;
  import pbs_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               in_kind = 0;
  logic [1:0]         in_action = 0;
  logic signed [17:0] in_noise = 0;
  logic signed [17:0] in_start_angle = 0;
  logic signed [17:0] in_start_rate = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_angle, out_angle_rate, out_position, out_velocity;
  logic               out_reward, out_running;
  logic               cfg_psel = 0;
  logic               cfg_penable = 0;
  logic               cfg_pwrite = 0;
  logic [4:0]         cfg_paddr = 0;
  logic [31:0]        cfg_pwdata = 0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  int  mismatches, awaited, states_seen, episodes_ended;
  int  cycles = 0;
  int  requests = 0;
  int  hold_left = 0;
  bit  gappy = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  pole_balance_sim_step_unit dut (.*);

  pole_balance_sim_step_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // in gappy mode, hold the result channel for a random count after each result
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      if (out_valid && !out_stall && gappy) hold_left <= $urandom_range(0, 15);
    end
  end

  task automatic send_request(logic kind, logic [1:0] act, logic signed [17:0] noise,
                              logic signed [17:0] sa, logic signed [17:0] sr);
    int gap;
    gap = gappy ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_action <= act;
    in_noise <= noise;
    in_start_angle <= sa;
    in_start_rate <= sr;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    requests++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  task automatic run_episodes(int n);
    logic signed [17:0] noise, sa, sr;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) gappy = !gappy;
      if ($urandom_range(0, 99) < 9) begin
        noise = $urandom;
        sa = $urandom;
        sr = $urandom;
      end else begin
        noise = $urandom_range(0, 131072) - 65536;
        sa = $urandom_range(0, 205888) - 102944;
        sr = $urandom_range(0, 131072) - 65536;
      end
      if ($urandom_range(0, 99) < 20)
        send_request(1, 2'($urandom), noise, sa, sr);
      else
        send_request(0, ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     noise, sa, sr);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // act before any episode start, then extremes of start values and noise
    send_request(0, ACT_RIGHT, 18'sd65536, 0, 0);
    send_request(1, 0, 0, 18'sd102944, 18'sd65536);
    send_request(0, ACT_LEFT, -18'sd65536, 0, 0);
    send_request(0, ACT_LEFT, 0, 18'sd5, 18'sd5);
    send_request(1, 0, 0, -18'sd102944, -18'sd65536);
    send_request(0, 2'd3, 18'sd131071, 0, 0);
    send_request(1, 2'd3, -18'sd131072, 18'sd131071, -18'sd131072);
    send_request(0, ACT_RIGHT, 0, 0, 0);
    send_request(1, 0, 0, 0, 0);
    for (int a = 0; a < 4; a++) send_request(0, 2'(a), 18'sd0, 0, 0);
    send_request(1, 0, 0, -18'sd131072, 18'sd131071);
    send_request(0, ACT_RIGHT, -18'sd131072, 0, 0);
    send_request(0, 2'd1, 0, 0, 0);
    send_request(1, 0, 0, 18'sd1000, -18'sd1000);
    send_request(0, 2'd1, 18'sd65536, -18'sd1, 18'sd1);

    run_episodes(280);

    // minimal substep and time step, zero length gives a zero denominator
    write_reg(REG_SUBSTEPS, 1);
    write_reg(REG_TSTEP, 1);
    write_reg(REG_LENGTH, 0);
    run_episodes(150);
    write_reg(REG_LENGTH, 131072);
    write_reg(REG_TSTEP, 6554);
    write_reg(REG_GRAVITY, 1048576);
    write_reg(REG_MASS, 262144);
    write_reg(REG_INV_MASS, 65536);
    run_episodes(150);

    // zero masses and gravity, then zero substeps and no integration at all
    write_reg(REG_GRAVITY, 0);
    write_reg(REG_MASS, 0);
    write_reg(REG_INV_MASS, 0);
    run_episodes(40);
    write_reg(REG_SUBSTEPS, 0);
    run_episodes(100);

    // substep count of 32, then masked out-of-range values
    write_reg(REG_SUBSTEPS, 32);
    write_reg(REG_GRAVITY, 642253);
    write_reg(REG_MASS, 131072);
    write_reg(REG_INV_MASS, 6554);
    write_reg(REG_TSTEP, 655);
    write_reg(REG_LENGTH, 32768);
    run_episodes(40);
    write_reg(REG_SUBSTEPS, 32'hffff_ffc3);
    write_reg(REG_TSTEP, 32'hffff_e28f);
    write_reg(REG_GRAVITY, 32'hffff_ffff);
    run_episodes(60);
    write_reg(REG_SUBSTEPS, 11);
    write_reg(REG_TSTEP, 655);
    write_reg(REG_GRAVITY, 642253);
    run_episodes(200);

    in_valid <= 0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d requests over several parameter sets, %0d results checked,",
             requests, states_seen);
    $display("%0d episodes ran to their end.", episodes_ended);
    if (mismatches == 0 && awaited == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
